>>> rtl/uvs_pkg.sv
// Shared constants, types and tables for the UV sphere vertex and index generator.
package uvs_pkg;

	localparam int MAX_SEGS       = 128;
	localparam int CORDIC_ITERS   = 16;

	// long division of {value, 31 zero bits} by n, one quotient bit per step
	localparam int DIV_BITS       = 40;
	localparam int DIV_PER_STAGE  = 8;
	localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;

	localparam int CORD_PER_STAGE = 2;
	localparam int CORD_STAGES    = (CORDIC_ITERS + CORD_PER_STAGE - 1) / CORD_PER_STAGE;
	// reduction stage + iteration stages + quadrant rotation stage
	localparam int CORD_LAT       = CORD_STAGES + 2;
	localparam int MUL_LAT        = 2;
	localparam int SCALE_LAT      = 2;

	// input register + datapath; sideband tap SB_DEPTH-1 lines up with the scaled positions
	localparam int SB_DEPTH       = 1 + DIV_STAGES + CORD_LAT + MUL_LAT + SCALE_LAT;
	localparam int LAT            = SB_DEPTH + 1;

	localparam logic signed [32:0] GAIN_Q30  = 33'sd652032874;
	localparam logic signed [19:0] POS_LIMIT = 20'sd65535;

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_SEGS   = 1'b1;

	typedef struct packed {
		logic        oor;
		logic        quad;
		logic [15:0] lo;
		logic [15:0] hi;
	} sideband_t;

	// arctangent of 2^-k as a binary angle (2^32 per turn)
	function automatic logic signed [31:0] atan_bam(input int k);
		logic signed [31:0] v;
		case (k)
			0:  v = 32'sd536870912;
			1:  v = 32'sd316933406;
			2:  v = 32'sd167458907;
			3:  v = 32'sd85004756;
			4:  v = 32'sd42667331;
			5:  v = 32'sd21354465;
			6:  v = 32'sd10679838;
			7:  v = 32'sd5340245;
			8:  v = 32'sd2670163;
			9:  v = 32'sd1335087;
			10: v = 32'sd667544;
			11: v = 32'sd333772;
			12: v = 32'sd166886;
			13: v = 32'sd83443;
			14: v = 32'sd41722;
			15: v = 32'sd20861;
			16: v = 32'sd10430;
			17: v = 32'sd5215;
			18: v = 32'sd2608;
			19: v = 32'sd1304;
			20: v = 32'sd652;
			21: v = 32'sd326;
			22: v = 32'sd163;
			23: v = 32'sd81;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/uv_sphere_vertex_index_gen_unit.sv
// UV sphere vertex and index generator top level.
// One item accepted every cycle; busy stays low.
// Depth is set by the 40-step divider (5 stages), the 16-step CORDIC (10 stages)
// and the two multiply-and-round pairs (4 stages).
// Reset clears the valid line and sets radius to 1.0 and the segment count to 8.
module uv_sphere_vertex_index_gen_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         ring,
	input  logic [8:0]         column,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic               quad_valid,
	output logic [15:0]        tri_a0,
	output logic [15:0]        tri_a1,
	output logic [15:0]        tri_a2,
	output logic [15:0]        tri_b0,
	output logic [15:0]        tri_b1,
	output logic [15:0]        tri_b2,
	output logic               out_of_range
);

	logic [15:0] radius_q;
	logic [7:0]  segs_q;
	logic [7:0]  n;
	logic [8:0]  n2, stride;

	logic        vld_s [uvs_pkg::SB_DEPTH];
	uvs_pkg::sideband_t sb_s [uvs_pkg::SB_DEPTH];
	uvs_pkg::sideband_t sb_in;

	logic [7:0]  ring_s1;
	logic [8:0]  column_s1;

	logic [31:0] q_phi, q_theta;
	logic signed [31:0] cp, sp, ct, st;
	logic signed [63:0] px_s1, pz_s1;
	logic signed [31:0] sp_s1;
	logic signed [32:0] vx_s2, vy_s2, vz_s2;
	logic signed [16:0] sx, sy, sz;

	logic               done_q;
	logic signed [16:0] pos_x_q, pos_y_q, pos_z_q;
	logic               quad_q, oor_q;
	logic [15:0]        lo_q, hi_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			segs_q   <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				uvs_pkg::REG_RADIUS: radius_q <= cfg_wdata;
				uvs_pkg::REG_SEGS:   segs_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// user changes config only while idle (unenforced); stages read it directly
	assign n      = (segs_q > 8'(uvs_pkg::MAX_SEGS)) ? 8'(uvs_pkg::MAX_SEGS) : segs_q;
	assign n2     = {n, 1'b0};
	assign stride = n2 + 9'd1;

	always_comb begin
		sb_in.oor  = (n == 8'd0) || (ring > n) || (column > n2);
		sb_in.quad = !sb_in.oor && (ring < n) && (column < n2);
		sb_in.lo   = 16'(ring) * 16'(stride) + 16'(column);
		sb_in.hi   = 16'(ring) * 16'(stride) + 16'(column) + 16'(stride);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < uvs_pkg::SB_DEPTH; k++)
				vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int k = 1; k < uvs_pkg::SB_DEPTH; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sb_s[0]   <= sb_in;
		ring_s1   <= ring;
		column_s1 <= column;
		for (int k = 1; k < uvs_pkg::SB_DEPTH; k++)
			sb_s[k] <= sb_s[k-1];
	end

	uvs_div u_div_phi (
		.clk      (clk),
		.dividend ({1'b0, ring_s1}),
		.n        (n),
		.quotient (q_phi)
	);

	uvs_div u_div_theta (
		.clk      (clk),
		.dividend (column_s1),
		.n        (n),
		.quotient (q_theta)
	);

	// phi starts at the south pole: a quarter turn back
	uvs_cordic u_cordic_phi (
		.clk     (clk),
		.angle   (q_phi),
		.qofs    (2'd1),
		.cos_val (cp),
		.sin_val (sp)
	);

	uvs_cordic u_cordic_theta (
		.clk     (clk),
		.angle   (q_theta),
		.qofs    (2'd0),
		.cos_val (ct),
		.sin_val (st)
	);

	always_ff @(posedge clk) begin
		px_s1 <= cp * ct;
		pz_s1 <= cp * st;
		sp_s1 <= sp;
		vx_s2 <= 33'((px_s1 + 64'sd536870912) >>> 30);
		vz_s2 <= 33'((pz_s1 + 64'sd536870912) >>> 30);
		vy_s2 <= 33'(sp_s1);
	end

	uvs_scale u_scale_x (.clk(clk), .radius(radius_q), .v(vx_s2), .pos(sx));
	uvs_scale u_scale_y (.clk(clk), .radius(radius_q), .v(vy_s2), .pos(sy));
	uvs_scale u_scale_z (.clk(clk), .radius(radius_q), .v(vz_s2), .pos(sz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s[uvs_pkg::SB_DEPTH-1];
	end

	always_ff @(posedge clk) begin
		oor_q   <= sb_s[uvs_pkg::SB_DEPTH-1].oor;
		quad_q  <= sb_s[uvs_pkg::SB_DEPTH-1].quad;
		lo_q    <= sb_s[uvs_pkg::SB_DEPTH-1].quad ? sb_s[uvs_pkg::SB_DEPTH-1].lo : 16'd0;
		hi_q    <= sb_s[uvs_pkg::SB_DEPTH-1].quad ? sb_s[uvs_pkg::SB_DEPTH-1].hi : 16'd0;
		pos_x_q <= sb_s[uvs_pkg::SB_DEPTH-1].oor ? 17'sd0 : sx;
		pos_y_q <= sb_s[uvs_pkg::SB_DEPTH-1].oor ? 17'sd0 : sy;
		pos_z_q <= sb_s[uvs_pkg::SB_DEPTH-1].oor ? 17'sd0 : sz;
	end

	assign done         = done_q;
	assign out_of_range = oor_q;
	assign quad_valid   = quad_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign tri_a0       = lo_q;
	assign tri_a1       = hi_q;
	assign tri_a2       = quad_q ? hi_q + 16'd1 : 16'd0;
	assign tri_b0       = lo_q;
	assign tri_b1       = quad_q ? hi_q + 16'd1 : 16'd0;
	assign tri_b2       = quad_q ? lo_q + 16'd1 : 16'd0;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(uvs_pkg::LAT) done)
		else $error("transfer did not reach the result port on time");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> !quad_valid && pos_x == 0 && pos_y == 0 && pos_z == 0)
		else $error("out of range result carries data");

	a_quad_rows: assert property (@(posedge clk) disable iff (!arst_n)
		done && quad_valid |-> tri_a2 == tri_a1 + 16'd1 && tri_b2 == tri_a0 + 16'd1)
		else $error("quad indices inconsistent");

	a_quad_oor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(quad_valid && out_of_range))
		else $error("quad flagged on out of range point");

endmodule

>>> rtl/uvs_div.sv
// Pipelined restoring divider: floor(dividend * 2^31 / n), low 32 bits.
module uvs_div (
	input  logic        clk,
	input  logic [8:0]  dividend,
	input  logic [7:0]  n,
	output logic [31:0] quotient
);

	logic [7:0]                     rem_s [uvs_pkg::DIV_STAGES];
	logic [uvs_pkg::DIV_BITS-1:0]   w_s   [uvs_pkg::DIV_STAGES];

	for (genvar g = 0; g < uvs_pkg::DIV_STAGES; g++) begin : g_stage
		logic [7:0]                   rem_in, rem_nx;
		logic [uvs_pkg::DIV_BITS-1:0] w_in, w_nx;
		logic [8:0]                   r9;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign w_in   = {dividend, {(uvs_pkg::DIV_BITS-9){1'b0}}};
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign w_in   = w_s[g-1];
		end

		// dividend bits leave at the top, quotient bits enter at the bottom
		always_comb begin
			rem_nx = rem_in;
			w_nx   = w_in;
			r9     = '0;
			for (int k = 0; k < uvs_pkg::DIV_PER_STAGE; k++) begin
				r9   = {rem_nx, w_nx[uvs_pkg::DIV_BITS-1]};
				w_nx = {w_nx[uvs_pkg::DIV_BITS-2:0], 1'b0};
				if (r9 >= {1'b0, n}) begin
					rem_nx  = 8'(r9 - {1'b0, n});
					w_nx[0] = 1'b1;
				end else begin
					rem_nx = r9[7:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_nx;
			w_s[g]   <= w_nx;
		end
	end

	assign quotient = w_s[uvs_pkg::DIV_STAGES-1][31:0];

endmodule

>>> rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC with quadrant reduction: cosine and sine in Q2.30.
module uvs_cordic (
	input  logic               clk,
	input  logic [31:0]        angle,
	input  logic [1:0]         qofs,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	logic [31:0]        biased;
	logic [1:0]         qa;
	logic [31:0]        rb;

	logic signed [32:0] x_s [uvs_pkg::CORD_STAGES+1];
	logic signed [32:0] y_s [uvs_pkg::CORD_STAGES+1];
	logic signed [31:0] z_s [uvs_pkg::CORD_STAGES+1];
	logic [1:0]         q_s [uvs_pkg::CORD_STAGES+1];
	logic signed [31:0] c_q, s_q;

	// quadrant by rounding to the nearest quarter turn; offset shifts whole quadrants
	assign biased = angle + 32'h2000_0000;
	assign qa     = biased[31:30];
	assign rb     = angle - {qa, 30'b0};

	always_ff @(posedge clk) begin
		x_s[0] <= uvs_pkg::GAIN_Q30;
		y_s[0] <= '0;
		z_s[0] <= signed'(rb);
		q_s[0] <= qa - qofs;
	end

	for (genvar g = 1; g <= uvs_pkg::CORD_STAGES; g++) begin : g_iter
		logic signed [32:0] x_nx, y_nx, dx, dy;
		logic signed [31:0] z_nx;

		always_comb begin
			x_nx = x_s[g-1];
			y_nx = y_s[g-1];
			z_nx = z_s[g-1];
			dx   = '0;
			dy   = '0;
			for (int m = 0; m < uvs_pkg::CORD_PER_STAGE; m++) begin
				if ((g-1)*uvs_pkg::CORD_PER_STAGE + m < uvs_pkg::CORDIC_ITERS) begin
					dx = y_nx >>> ((g-1)*uvs_pkg::CORD_PER_STAGE + m);
					dy = x_nx >>> ((g-1)*uvs_pkg::CORD_PER_STAGE + m);
					if (z_nx >= 0) begin
						x_nx = x_nx - dx;
						y_nx = y_nx + dy;
						z_nx = z_nx - uvs_pkg::atan_bam((g-1)*uvs_pkg::CORD_PER_STAGE + m);
					end else begin
						x_nx = x_nx + dx;
						y_nx = y_nx - dy;
						z_nx = z_nx + uvs_pkg::atan_bam((g-1)*uvs_pkg::CORD_PER_STAGE + m);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			x_s[g] <= x_nx;
			y_s[g] <= y_nx;
			z_s[g] <= z_nx;
			q_s[g] <= q_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		case (q_s[uvs_pkg::CORD_STAGES])
			2'd0: begin
				c_q <= 32'(x_s[uvs_pkg::CORD_STAGES]);
				s_q <= 32'(y_s[uvs_pkg::CORD_STAGES]);
			end
			2'd1: begin
				c_q <= 32'(-y_s[uvs_pkg::CORD_STAGES]);
				s_q <= 32'(x_s[uvs_pkg::CORD_STAGES]);
			end
			2'd2: begin
				c_q <= 32'(-x_s[uvs_pkg::CORD_STAGES]);
				s_q <= 32'(-y_s[uvs_pkg::CORD_STAGES]);
			end
			default: begin
				c_q <= 32'(y_s[uvs_pkg::CORD_STAGES]);
				s_q <= 32'(-x_s[uvs_pkg::CORD_STAGES]);
			end
		endcase
	end

	assign cos_val = c_q;
	assign sin_val = s_q;

endmodule

>>> rtl/uvs_scale.sv
// Radius scaling of one Q2.30 factor to a saturated Q8.8 coordinate, two stages.
module uvs_scale (
	input  logic               clk,
	input  logic [15:0]        radius,
	input  logic signed [32:0] v,
	output logic signed [16:0] pos
);

	logic signed [49:0] p_s1;
	logic signed [49:0] r;
	logic signed [16:0] pos_s2;

	always_ff @(posedge clk) begin
		p_s1 <= 50'($signed({1'b0, radius}) * v);
	end

	assign r = (p_s1 + 50'sd536870912) >>> 30;

	always_ff @(posedge clk) begin
		if (r > 50'(uvs_pkg::POS_LIMIT))
			pos_s2 <= 17'(uvs_pkg::POS_LIMIT);
		else if (r < -50'(uvs_pkg::POS_LIMIT))
			pos_s2 <= 17'(-uvs_pkg::POS_LIMIT);
		else
			pos_s2 <= 17'(r);
	end

	assign pos = pos_s2;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the UV sphere vertex and index generator.
module tb_top;

	typedef struct {
		logic signed [16:0] px, py, pz;
		logic               qv;
		logic [15:0]        a0, a1, a2, b0, b1, b2;
		logic               oor;
	} vertex_t;

	localparam longint ARCTAN [24] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	// shadow of the geometry registers plus the vertex/index math
	class vertex_scoreboard;
		int unsigned rad = 256;
		int unsigned segs = 8;
		vertex_t pending[$];
		int errors = 0;
		int checked = 0;

		function longint fdiv(longint v, int k);
			return v >>> k;
		endfunction

		function void sincos(logic [31:0] ang, output longint c, output longint s);
			logic [31:0] q, rb;
			longint x, y, z, dx, dy;
			q = ((ang + 32'h2000_0000) >> 30) & 3;
			rb = ang - (q << 30);
			z = longint'($signed(rb));
			x = 652032874;
			y = 0;
			for (int k = 0; k < uvs_pkg::CORDIC_ITERS && k < 24; k++) begin
				dx = fdiv(y, k);
				dy = fdiv(x, k);
				if (z >= 0) begin
					x -= dx; y += dy; z -= ARCTAN[k];
				end else begin
					x += dx; y -= dy; z += ARCTAN[k];
				end
			end
			case (q)
				0: begin c = x; s = y; end
				1: begin c = -y; s = x; end
				2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function logic signed [16:0] scale(longint v);
			longint p;
			p = fdiv(longint'(rad) * v + (64'sd1 <<< 29), 30);
			if (p > 65535) p = 65535;
			if (p < -65535) p = -65535;
			return p[16:0];
		endfunction

		function void note_cell(int unsigned i, int unsigned j);
			vertex_t e;
			longint unsigned n, sr, lo, hi;
			logic [31:0] phi, th;
			longint cp, sp, ct, st;
			e = '{default: 0};
			n = (segs > uvs_pkg::MAX_SEGS) ? uvs_pkg::MAX_SEGS : segs;
			if (n == 0 || i > n || j > 2 * n) begin
				e.oor = 1;
			end else begin
				phi = 32'(((longint'(i) << 31) / n) - 64'h4000_0000);
				th = 32'((longint'(j) << 31) / n);
				sincos(phi, cp, sp);
				sincos(th, ct, st);
				e.px = scale(fdiv(cp * ct + (64'sd1 <<< 29), 30));
				e.py = scale(sp);
				e.pz = scale(fdiv(cp * st + (64'sd1 <<< 29), 30));
				if (i < n && j < 2 * n) begin
					sr = 2 * n + 1;
					lo = i * sr + j;
					hi = (i + 1) * sr + j;
					e.qv = 1;
					e.a0 = 16'(lo); e.a1 = 16'(hi); e.a2 = 16'(hi + 1);
					e.b0 = 16'(lo); e.b1 = 16'(hi + 1); e.b2 = 16'(lo + 1);
				end
			end
			pending.push_back(e);
		endfunction

		function void report(string what, longint got, longint want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endfunction

		function void check_vertex(vertex_t g);
			vertex_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("unexpected result transfer");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (g.px !== e.px) report("pos_x", g.px, e.px);
			if (g.py !== e.py) report("pos_y", g.py, e.py);
			if (g.pz !== e.pz) report("pos_z", g.pz, e.pz);
			if (g.qv !== e.qv) report("quad_valid", g.qv, e.qv);
			if (g.a0 !== e.a0) report("tri_a0", g.a0, e.a0);
			if (g.a1 !== e.a1) report("tri_a1", g.a1, e.a1);
			if (g.a2 !== e.a2) report("tri_a2", g.a2, e.a2);
			if (g.b0 !== e.b0) report("tri_b0", g.b0, e.b0);
			if (g.b1 !== e.b1) report("tri_b1", g.b1, e.b1);
			if (g.b2 !== e.b2) report("tri_b2", g.b2, e.b2);
			if (g.oor !== e.oor) report("out_of_range", g.oor, e.oor);
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0, busy, cfg_we = 0, cfg_idx = 0, done;
	logic [7:0] ring = 0;
	logic [8:0] column = 0;
	logic [15:0] cfg_wdata = 0;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic quad_valid, out_of_range;
	logic [15:0] tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2;

	vertex_scoreboard sb = new();
	int idle_pct = 0;
	longint cycles = 0;

	uv_sphere_vertex_index_gen_unit uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_vertex('{pos_x, pos_y, pos_z, quad_valid, tri_a0, tri_a1, tri_a2,
				tri_b0, tri_b1, tri_b2, out_of_range});
		if (arst_n && start && !busy)
			sb.note_cell(ring, column);
	end

	// one cell transfer, with random idle cycles ahead of it
	task send_cell(input int unsigned i, input int unsigned j);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		ring <= 8'(i);
		column <= 9'(j);
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task drain();
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (uvs_pkg::LAT + 4) @(negedge clk);
	endtask

	task write_reg(input logic idx, input int unsigned val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= 16'(val);
		@(negedge clk);
		cfg_we <= 0;
		if (idx == uvs_pkg::REG_RADIUS) sb.rad = val & 16'hFFFF;
		else sb.segs = val & 8'hFF;
	endtask

	// mostly in-range cells, some past the edges, and the odd fully random one
	task random_cells(input int cnt);
		int unsigned n;
		n = (sb.segs > uvs_pkg::MAX_SEGS) ? uvs_pkg::MAX_SEGS : sb.segs;
		for (int k = 0; k < cnt; k++) begin
			case ($urandom_range(9))
				0: send_cell($urandom_range(255), $urandom_range(511));
				1: send_cell($urandom_range(n + 2), $urandom_range(2 * n + 2));
				default: send_cell($urandom_range(n), $urandom_range(2 * n));
			endcase
		end
	endtask

	initial begin
		int segset [6];
		segset = '{1, 128, 8, 3, 200, 37};
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: reset geometry, corners, poles, seam, out of range
		send_cell(0, 0); send_cell(8, 16); send_cell(4, 8); send_cell(7, 15);
		send_cell(8, 0); send_cell(0, 16); send_cell(9, 0); send_cell(0, 17);
		send_cell(255, 511); send_cell(3, 5);
		drain();
		write_reg(uvs_pkg::REG_SEGS, 0);
		send_cell(0, 0); send_cell(1, 1);
		drain();
		write_reg(uvs_pkg::REG_SEGS, 128);
		write_reg(uvs_pkg::REG_RADIUS, 16'hFFFF);
		send_cell(128, 256); send_cell(127, 255); send_cell(64, 128); send_cell(0, 0);
		send_cell(128, 0); send_cell(129, 0); send_cell(170, 341);
		drain();
		write_reg(uvs_pkg::REG_SEGS, 255);
		send_cell(128, 256); send_cell(0, 1);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(uvs_pkg::REG_SEGS, segset[ph]);
			case (ph % 3)
				0: write_reg(uvs_pkg::REG_RADIUS, $urandom_range(65535));
				1: write_reg(uvs_pkg::REG_RADIUS, 0);
				default: write_reg(uvs_pkg::REG_RADIUS, 16'hFFFF);
			endcase
			idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 87 : 12);
			random_cells(65);
			drain();
			random_cells(65);
			drain();
		end
		idle_pct = 0;
		drain();
		$display("covered %0d results over several segment counts and radii", sb.checked);
		$display("including out-of-range cells, poles, seams and idle gaps");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
